// ===== sv/kssfl_pkg.sv =====
// kssfl_pkg: shared constants, codes and types for the k-stacks free-list block
// no dependencies

package kssfl_pkg;

  // store geometry
  localparam int NUM_SLOTS  = 16;
  localparam int NUM_STACKS = 4;

  // slot index width, and link width with room for the null code
  localparam int SLOT_IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LINK_W   = $clog2(NUM_SLOTS + 1);
  localparam int STACK_IW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // null link is encoded as NUM_SLOTS
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

  // value returned on underflow
  localparam logic signed [31:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef logic [LINK_W-1:0] link_t;

  // a link names a real slot only below NUM_SLOTS
  function automatic logic is_slot(link_t l);
    return (32'(l) < NUM_SLOTS);
  endfunction

endpackage

// ===== sv/k_stacks_shared_free_list.sv =====
// k_stacks_shared_free_list: several LIFO stacks threaded through one slot store
// depends on kssfl_pkg
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, mode, stack_id,    | item in
//          | push_value                                |
//  out     | out_valid_o/out_ready_i, result_value,    | item out
//          | status, store_full, stack_empty           |
//
// one item per cycle while results are taken; each item's result shows in the cycle after it is accepted
// the whole step (free-list head, stack top and one link read) settles combinationally
// from the input ports into the result register and the state registers
// reset puts every slot on the free list in order and empties all stacks
// a held result stalls input only when out_ready_i is low

module k_stacks_shared_free_list
  import kssfl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [1:0]         stack_id_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic               store_full_o,
  output logic               stack_empty_o
);

  // store state
  logic signed [31:0] slot_values_q [NUM_SLOTS];
  link_t              slot_links_q  [NUM_SLOTS];
  link_t              stack_tops_q  [NUM_STACKS];
  link_t              free_head_q, free_head_d;

  // result register
  logic               out_valid_q;
  logic signed [31:0] result_value_q, result_value_d;
  status_e            status_q, status_d;
  logic               store_full_q, store_full_d;
  logic               stack_empty_q, stack_empty_d;

  // step signals
  logic                in_acc;
  logic                sid_ok;
  logic [STACK_IW-1:0] sid_idx;
  link_t               top;
  link_t               rd_addr;
  link_t               link_rd;
  logic signed [31:0]  val_rd;
  logic                link_we;
  link_t               link_waddr;
  link_t               link_wdata;
  logic                val_we;
  logic                top_we;
  link_t               top_wdata;
  link_t               new_top;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // addressed stack and its top
  assign sid_ok  = (32'(stack_id_i) < NUM_STACKS);
  assign sid_idx = STACK_IW'(stack_id_i);
  assign top     = sid_ok ? stack_tops_q[sid_idx] : NULL_LINK;

  // single link read: free head for push, stack top otherwise
  assign rd_addr = (mode_i == MODE_PUSH) ? free_head_q : top;
  assign link_rd = is_slot(rd_addr) ? slot_links_q[rd_addr[SLOT_IW-1:0]] : NULL_LINK;
  assign val_rd  = slot_values_q[top[SLOT_IW-1:0]];

  // one operation: next state and result
  always_comb begin
    free_head_d    = free_head_q;
    link_we        = 1'b0;
    link_waddr     = free_head_q;
    link_wdata     = top;
    val_we         = 1'b0;
    top_we         = 1'b0;
    top_wdata      = top;
    result_value_d = '0;
    status_d       = ST_OK;
    if (sid_ok) begin
      case (mode_i)
        MODE_PUSH: begin
          if (!is_slot(free_head_q)) begin
            status_d = ST_OVERFLOW;
          end else begin
            free_head_d = link_rd;
            link_we     = 1'b1;
            link_waddr  = free_head_q;
            link_wdata  = top;
            val_we      = 1'b1;
            top_we      = 1'b1;
            top_wdata   = free_head_q;
          end
        end
        MODE_POP: begin
          if (!is_slot(top)) begin
            status_d       = ST_UNDERFLOW;
            result_value_d = UNDERFLOW_VALUE;
          end else begin
            top_we         = 1'b1;
            top_wdata      = link_rd;
            link_we        = 1'b1;
            link_waddr     = top;
            link_wdata     = free_head_q;
            free_head_d    = top;
            result_value_d = val_rd;
          end
        end
        MODE_PEEK: begin
          if (!is_slot(top)) begin
            status_d       = ST_UNDERFLOW;
            result_value_d = UNDERFLOW_VALUE;
          end else begin
            result_value_d = val_rd;
          end
        end
        default: begin
          // unused code leaves everything alone
        end
      endcase
    end
    new_top       = top_we ? top_wdata : top;
    stack_empty_d = !sid_ok || !is_slot(new_top);
    store_full_d  = !is_slot(free_head_d);
  end

  // control and link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_links_q[i] <= LINK_W'(i + 1);
      end
      for (int j = 0; j < NUM_STACKS; j++) begin
        stack_tops_q[j] <= NULL_LINK;
      end
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
        free_head_q <= free_head_d;
        if (link_we) begin
          slot_links_q[link_waddr[SLOT_IW-1:0]] <= link_wdata;
        end
        if (top_we) begin
          stack_tops_q[sid_idx] <= top_wdata;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // slot values and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (val_we) begin
        slot_values_q[free_head_q[SLOT_IW-1:0]] <= push_value_i;
      end
      result_value_q <= result_value_d;
      status_q       <= status_d;
      store_full_q   <= store_full_d;
      stack_empty_q  <= stack_empty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign status_o       = status_q;
  assign store_full_o   = store_full_q;
  assign stack_empty_o  = stack_empty_q;

endmodule

// ===== sv/kssfl_checker.sv =====
// kssfl_checker: port-level checks for k_stacks_shared_free_list, and its bind
// depends on kssfl_pkg

module kssfl_checker
  import kssfl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         mode_i,
  input logic [1:0]         stack_id_i,
  input logic signed [31:0] push_value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] result_value_o,
  input logic [1:0]         status_o,
  input logic               store_full_o,
  input logic               stack_empty_o
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // every accepted item yields a result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // input stalls only behind a held result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no result waiting");

  // overflow only when the store is full, with a zero result value
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OVERFLOW) |-> store_full_o && (result_value_o == 0))
    else $error("overflow reported on a store with free slots");

  // underflow leaves the stack empty and returns the marker value
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_UNDERFLOW)
      |-> stack_empty_o && (result_value_o == UNDERFLOW_VALUE))
    else $error("underflow result is malformed");

endmodule

bind k_stacks_shared_free_list kssfl_checker u_kssfl_checker (.*);
